>>> rtl/core/fem_pkg.sv
// Shared types and constants of the fee escalation metrics block.
package fem_pkg;

  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEVEL_W = 64;
  localparam int unsigned DIV_W = 80;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned DEN_W = 32;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_QUOTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TXN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TXN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TXN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MULT = 3'd4;

  localparam logic [15:0] BASE_LEVEL_RST = 16'd256;
  localparam logic [10:0] MIN_TXN_RST = 11'd5;
  localparam logic [10:0] TARGET_TXN_RST = 11'd50;
  localparam logic [10:0] MAX_TXN_RST = 11'd0;
  localparam logic [31:0] MIN_MULT_RST = 32'd128000;
  localparam logic [10:0] EXPECTED_RST = 11'd5;
  localparam logic [31:0] MULT_RST = 32'd128000;

  typedef struct packed {
    logic [1:0]  command;
    logic [56:0] fee_drops;
    logic [31:0] base_fee_drops;
    logic        time_leap;
    logic [15:0] open_count;
  } in_t;

  typedef struct packed {
    logic [63:0] fee_level;
    logic [10:0] expected_count;
    logic [31:0] multiplier;
    logic [10:0] ledger_size;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul_add;
    logic mul_q1;
    logic mul_q2;
    logic mul_q3;
    logic div_start;
    logic sel_init;
    logic scan_start;
    logic scan_step;
    logic sel_bit;
    logic fin_div;
    logic fin_qlow;
    logic fin_close;
    logic fin_none;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic bit_last;
    logic count_zero;
    logic quote_hi;
  } dp_sts_t;

endpackage

>>> rtl/core/fee_escalation_metrics.sv
// Top level of the fee escalation metrics block.
// A command is taken when start_i is high and busy_o is low; its one result
// appears on res_o for a single cycle with done_o high and must be taken then.
// An add and a quote above the expected count both wait for the 80-step
// divider; a quote at or below it and the unused command need no division.
// A close with stored levels runs one scan per median bit: each of the 64 median
// bits is one pass over the level store through its single read port; a close
// on an empty store skips the scans.
module fee_escalation_metrics #(
  parameter int unsigned LEDGER_TXNS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fem_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           start_i,
  input  fem_pkg::in_t                   in_i,
  output logic                           busy_o,
  output logic                           done_o,
  output fem_pkg::out_t                  res_o
);

  fem_pkg::dp_cmd_t dp_cmd;
  fem_pkg::dp_sts_t dp_sts;

  fem_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (in_i.command),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd),
    .busy_o    (busy_o)
  );

  fem_dp #(
    .LEDGER_TXNS (LEDGER_TXNS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not make the block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result transfer while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result transfers in a row");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.overflow |-> res_o.ledger_size == 11'(LEDGER_TXNS))
    else $error("overflow reported with store not full");

endmodule

>>> rtl/core/fem_div.sv
// Restoring divider that produces one quotient bit per cycle, saturated to 64 bits.
module fem_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fem_pkg::DIV_W-1:0]     dividend_i,
  input  logic [fem_pkg::DEN_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [fem_pkg::LEVEL_W-1:0]   quot_o
);

  logic [fem_pkg::DIV_W-1:0]     qr_q, qr_d;
  logic [fem_pkg::DEN_W:0]       rem_q, rem_d;
  logic [fem_pkg::DEN_W-1:0]     dvs_q, dvs_d;
  logic [fem_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [fem_pkg::DEN_W:0]       sh;
  logic                          qbit;

  always_comb begin
    qr_d = qr_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    sh = {rem_q[fem_pkg::DEN_W-1:0], qr_q[fem_pkg::DIV_W-1]};
    qbit = (sh >= {1'b0, dvs_q});
    if (start_i) begin
      qr_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = fem_pkg::DIV_CNT_W'(fem_pkg::DIV_W - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = qbit ? (sh - {1'b0, dvs_q}) : sh;
      qr_d = {qr_q[fem_pkg::DIV_W-2:0], qbit};
      if (cnt_q == '0) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q <= qr_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = (|qr_q[fem_pkg::DIV_W-1:fem_pkg::LEVEL_W]) ? '1
                : qr_q[fem_pkg::LEVEL_W-1:0];

endmodule

>>> rtl/core/fem_dp.sv
// Datapath: configuration, level store, multipliers, divider and median selection.
module fem_dp #(
  parameter int unsigned LEDGER_TXNS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fem_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fem_pkg::CFG_W-1:0]       cfg_data_i,
  input  fem_pkg::in_t                    in_i,
  input  fem_pkg::dp_cmd_t                cmd_i,
  output fem_pkg::dp_sts_t                sts_o,
  output logic                            done_o,
  output fem_pkg::out_t                   res_o
);

  localparam int unsigned CW = $clog2(LEDGER_TXNS + 1);
  localparam int unsigned AW = $clog2(LEDGER_TXNS);
  localparam int unsigned SW = (CW > 11) ? CW : 11;

  logic [15:0] base_level_q;
  logic [10:0] min_txn_q, target_txn_q, max_txn_q;
  logic [31:0] min_mult_q;

  fem_pkg::in_t in_q;
  logic [CW-1:0] count_q, count_d;
  logic [10:0]   exp_q, exp_d;
  logic [31:0]   mult_q, mult_d;

  logic [63:0] prod_q;
  logic [fem_pkg::DIV_W-1:0] num_q;
  logic [fem_pkg::DEN_W-1:0] den_q;
  logic [72:0] add_prod;
  logic [31:0] oc_sq;
  logic [63:0] q2_prod;
  logic [79:0] q3_prod;
  logic [21:0] exp_sq;

  logic [63:0] mem_q [LEDGER_TXNS];
  logic [63:0] rd_q;
  logic        rd_vld_q;
  logic [CW-1:0] scan_addr_q, cnt_a_q, cnt_b_q, ka_q, kb_q;
  logic [63:0] pfx_a_q, pfx_b_q;
  logic [5:0]  bit_q;
  logic [63:0] hmask;
  logic        match_a, match_b, scan_more;

  logic        div_done;
  logic [63:0] div_quot;

  fem_pkg::out_t res_d, res_q;
  logic          done_q;
  logic          store_we;

  logic [SW-1:0] size_w, mn_w, tg_w, mx_w, ex_w, exp_new;
  logic [63:0]   med_sum;
  logic [31:0]   med;

  fem_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign add_prod = in_q.fee_drops * base_level_q;
  assign oc_sq = in_q.open_count * in_q.open_count;
  assign q2_prod = prod_q[31:0] * mult_q;
  assign q3_prod = prod_q * base_level_q;
  assign exp_sq = exp_q * exp_q;

  assign hmask = ~({64{1'b1}} >> (6'd63 - bit_q));
  assign match_a = (((rd_q ^ pfx_a_q) & hmask) == '0) && !rd_q[bit_q];
  assign match_b = (((rd_q ^ pfx_b_q) & hmask) == '0) && !rd_q[bit_q];
  assign scan_more = (scan_addr_q < count_q);

  assign size_w = SW'(count_q);
  assign mn_w = SW'(min_txn_q);
  assign tg_w = SW'(target_txn_q);
  assign mx_w = SW'(max_txn_q);
  assign ex_w = SW'(exp_q);
  assign med_sum = pfx_a_q + pfx_b_q + 64'd1;

  always_comb begin
    if (in_q.time_leap) begin
      if (size_w < mn_w) begin
        exp_new = mn_w;
      end else if (tg_w < size_w) begin
        exp_new = tg_w;
      end else begin
        exp_new = size_w;
      end
    end else if ((size_w > ex_w) || (size_w > tg_w)) begin
      exp_new = ((mx_w != '0) && (mx_w < size_w)) ? mx_w : size_w;
    end else begin
      exp_new = ex_w;
    end
    if (count_q == '0) begin
      med = min_mult_q;
    end else if (med_sum[32:1] < min_mult_q) begin
      med = min_mult_q;
    end else begin
      med = med_sum[32:1];
    end
  end

  always_comb begin
    count_d = count_q;
    exp_d = exp_q;
    mult_d = mult_q;
    store_we = 1'b0;
    res_d.fee_level = '0;
    res_d.overflow = 1'b0;
    res_d.ledger_size = 11'(count_q);
    if (cmd_i.fin_div && (in_q.command == fem_pkg::CMD_ADD)) begin
      res_d.fee_level = div_quot;
      if (count_q < CW'(LEDGER_TXNS)) begin
        store_we = 1'b1;
        count_d = count_q + 1'b1;
        res_d.ledger_size = 11'(count_q + 1'b1);
      end else begin
        res_d.overflow = 1'b1;
      end
    end else if (cmd_i.fin_div) begin
      res_d.fee_level = div_quot;
    end else if (cmd_i.fin_qlow) begin
      res_d.fee_level = 64'(base_level_q);
    end else if (cmd_i.fin_close) begin
      exp_d = 11'(exp_new);
      mult_d = med;
      count_d = '0;
    end
    res_d.expected_count = exp_d;
    res_d.multiplier = mult_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_level_q <= fem_pkg::BASE_LEVEL_RST;
      min_txn_q <= fem_pkg::MIN_TXN_RST;
      target_txn_q <= fem_pkg::TARGET_TXN_RST;
      max_txn_q <= fem_pkg::MAX_TXN_RST;
      min_mult_q <= fem_pkg::MIN_MULT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fem_pkg::CFG_BASE_LEVEL: base_level_q <= cfg_data_i[15:0];
        fem_pkg::CFG_MIN_TXN:    min_txn_q <= cfg_data_i[10:0];
        fem_pkg::CFG_TARGET_TXN: target_txn_q <= cfg_data_i[10:0];
        fem_pkg::CFG_MAX_TXN:    max_txn_q <= cfg_data_i[10:0];
        fem_pkg::CFG_MIN_MULT:   min_mult_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      exp_q <= fem_pkg::EXPECTED_RST;
      mult_q <= fem_pkg::MULT_RST;
      done_q <= 1'b0;
      rd_vld_q <= 1'b0;
      scan_addr_q <= '0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ka_q <= '0;
      kb_q <= '0;
      bit_q <= '0;
    end else begin
      count_q <= count_d;
      exp_q <= exp_d;
      mult_q <= mult_d;
      done_q <= cmd_i.fin_div | cmd_i.fin_qlow | cmd_i.fin_close | cmd_i.fin_none;
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        rd_vld_q <= cmd_i.scan_step && scan_more;
        if (cmd_i.scan_step && scan_more) begin
          scan_addr_q <= scan_addr_q + 1'b1;
        end
        if (rd_vld_q && match_a) begin
          cnt_a_q <= cnt_a_q + 1'b1;
        end
        if (rd_vld_q && match_b) begin
          cnt_b_q <= cnt_b_q + 1'b1;
        end
      end
      if (cmd_i.sel_init) begin
        ka_q <= count_q >> 1;
        kb_q <= (count_q - 1'b1) >> 1;
        bit_q <= 6'd63;
      end else if (cmd_i.sel_bit) begin
        if (ka_q >= cnt_a_q) begin
          ka_q <= ka_q - cnt_a_q;
        end
        if (kb_q >= cnt_b_q) begin
          kb_q <= kb_q - cnt_b_q;
        end
        bit_q <= bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.mul_add) begin
      num_q <= fem_pkg::DIV_W'(add_prod);
      den_q <= in_q.base_fee_drops;
    end
    if (cmd_i.mul_q1) begin
      prod_q <= 64'(oc_sq);
    end
    if (cmd_i.mul_q2) begin
      prod_q <= q2_prod;
    end
    if (cmd_i.mul_q3) begin
      num_q <= q3_prod;
      den_q <= fem_pkg::DEN_W'(exp_sq);
    end
    if (cmd_i.sel_init) begin
      pfx_a_q <= '0;
      pfx_b_q <= '0;
    end else if (cmd_i.sel_bit) begin
      if (ka_q >= cnt_a_q) begin
        pfx_a_q <= pfx_a_q | (64'd1 << bit_q);
      end
      if (kb_q >= cnt_b_q) begin
        pfx_b_q <= pfx_b_q | (64'd1 << bit_q);
      end
    end
    if (store_we) begin
      mem_q[count_q[AW-1:0]] <= div_quot;
    end
    rd_q <= mem_q[scan_addr_q[AW-1:0]];
    if (done_q == 1'b0 || res_d != res_q) begin
      res_q <= res_d;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.scan_done = !scan_more && !rd_vld_q;
  assign sts_o.bit_last = (bit_q == '0);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.quote_hi = (in_q.open_count > 16'(exp_q));
  assign done_o = done_q;
  assign res_o = res_q;

endmodule

>>> rtl/core/fem_ctrl.sv
// Controller state machine that sequences the datapath for each command.
module fem_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         command_i,
  input  fem_pkg::dp_sts_t   sts_i,
  output fem_pkg::dp_cmd_t   cmd_o,
  output logic               busy_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AMUL   = 4'd1;
  localparam logic [3:0] S_Q1     = 4'd2;
  localparam logic [3:0] S_Q2     = 4'd3;
  localparam logic [3:0] S_Q3     = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_SINIT  = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_SBIT   = 4'd9;
  localparam logic [3:0] S_CFIN   = 4'd10;
  localparam logic [3:0] S_NONE   = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (command_i)
            fem_pkg::CMD_ADD:   state_d = S_AMUL;
            fem_pkg::CMD_CLOSE: state_d = S_SINIT;
            fem_pkg::CMD_QUOTE: state_d = S_Q1;
            default:            state_d = S_NONE;
          endcase
        end
      end
      S_AMUL: begin
        cmd_o.mul_add = 1'b1;
        state_d = S_DSTART;
      end
      S_Q1: begin
        if (sts_i.quote_hi) begin
          cmd_o.mul_q1 = 1'b1;
          state_d = S_Q2;
        end else begin
          cmd_o.fin_qlow = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_Q2: begin
        cmd_o.mul_q2 = 1'b1;
        state_d = S_Q3;
      end
      S_Q3: begin
        cmd_o.mul_q3 = 1'b1;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.fin_div = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SINIT: begin
        cmd_o.sel_init = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d = sts_i.count_zero ? S_CFIN : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_SBIT;
        end
      end
      S_SBIT: begin
        cmd_o.sel_bit = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d = sts_i.bit_last ? S_CFIN : S_SCAN;
      end
      S_CFIN: begin
        cmd_o.fin_close = 1'b1;
        state_d = S_IDLE;
      end
      S_NONE: begin
        cmd_o.fin_none = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> verif/fee_escalation_metrics_tb.sv
// Self-checking testbench of the fee escalation metrics block.
module fee_escalation_metrics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e                        kind;
    fem_pkg::in_t                    item;
    logic [fem_pkg::CFG_IDX_W-1:0]   idx;
    logic [fem_pkg::CFG_W-1:0]       data;
  } op_t;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [fem_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [fem_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          start_i = 1'b0;
  fem_pkg::in_t                  in_i = '0;
  logic                          busy_o;
  logic                          done_o;
  fem_pkg::out_t                 res_o;

  fee_escalation_metrics i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .in_i, .busy_o, .done_o, .res_o
  );

  op_t pending_ops[$];
  fem_pkg::out_t results_due[$];

  logic [15:0] base_level_q = fem_pkg::BASE_LEVEL_RST;
  logic [10:0] min_txn_q = fem_pkg::MIN_TXN_RST;
  logic [10:0] target_txn_q = fem_pkg::TARGET_TXN_RST;
  logic [10:0] max_txn_q = fem_pkg::MAX_TXN_RST;
  logic [31:0] min_mult_q = fem_pkg::MIN_MULT_RST;
  logic [63:0] stored_levels[$];
  logic [10:0] expected_q = fem_pkg::EXPECTED_RST;
  logic [31:0] mult_q = fem_pkg::MULT_RST;

  int unsigned mismatches = 0;
  int unsigned n_add = 0, n_close = 0, n_quote = 0, n_full = 0, n_results = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0, gap_left = 0, quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] scale_sat(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] quo;
    if (d == 0) return ALL_ONES;
    if (b == 0) return 64'd0;
    quo = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
    return (quo[127:64] != 0) ? ALL_ONES : quo[63:0];
  endfunction

  function automatic fem_pkg::out_t fee_predict(fem_pkg::in_t it);
    fem_pkg::out_t r;
    logic [63:0] srt[$];
    logic [10:0] sz;
    logic [10:0] ex;
    logic [63:0] mid;
    logic [31:0] m;
    r = '0;
    case (it.command)
      fem_pkg::CMD_ADD: begin
        r.fee_level = scale_sat({7'd0, it.fee_drops}, {40'd0, base_level_q, 8'd0},
                                {24'd0, it.base_fee_drops, 8'd0});
        if (stored_levels.size() < STORE_DEPTH)
          stored_levels.insert(stored_levels.size(), r.fee_level);
        else r.overflow = 1'b1;
        r.ledger_size = 11'(stored_levels.size());
      end
      fem_pkg::CMD_CLOSE: begin
        sz = 11'(stored_levels.size());
        ex = expected_q;
        if (it.time_leap) begin
          if (sz < min_txn_q) ex = min_txn_q;
          else if (target_txn_q < sz) ex = target_txn_q;
          else ex = sz;
        end else if (sz > ex || sz > target_txn_q) begin
          ex = (max_txn_q != 0 && max_txn_q < sz) ? max_txn_q : sz;
        end
        if (sz == 0) begin
          m = min_mult_q;
        end else begin
          srt = stored_levels;
          srt.sort();
          mid = srt[sz / 2] + srt[(sz - 1) / 2] + 64'd1;
          m = mid[32:1];
          if (m < min_mult_q) m = min_mult_q;
        end
        expected_q = ex;
        mult_q = m;
        stored_levels.delete();
        r.ledger_size = sz;
      end
      fem_pkg::CMD_QUOTE: begin
        if ({16'd0, it.open_count} > {21'd0, expected_q})
          r.fee_level = scale_sat({32'd0, 32'(it.open_count) * 32'(it.open_count)}
                                  * {32'd0, mult_q},
                                  {48'd0, base_level_q},
                                  {42'd0, 22'(expected_q) * 22'(expected_q)});
        else
          r.fee_level = {48'd0, base_level_q};
        r.ledger_size = 11'(stored_levels.size());
      end
      default: r.ledger_size = 11'(stored_levels.size());
    endcase
    r.expected_count = expected_q;
    r.multiplier = mult_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  // Predicts at acceptance, checks each result transfer and watches for a hang.
  always @(posedge clk_i) begin
    fem_pkg::out_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("MISMATCH: result with nothing expected");
        end else begin
          exp_r = results_due.pop_front();
          check_field("fee_level", exp_r.fee_level, res_o.fee_level);
          check_field("expected_count", 64'(exp_r.expected_count),
                      64'(res_o.expected_count));
          check_field("multiplier", 64'(exp_r.multiplier), 64'(res_o.multiplier));
          check_field("ledger_size", 64'(exp_r.ledger_size), 64'(res_o.ledger_size));
          check_field("overflow", 64'(exp_r.overflow), 64'(res_o.overflow));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fem_pkg::CFG_BASE_LEVEL: base_level_q = cfg_data_i[15:0];
          fem_pkg::CFG_MIN_TXN:    min_txn_q = cfg_data_i[10:0];
          fem_pkg::CFG_TARGET_TXN: target_txn_q = cfg_data_i[10:0];
          fem_pkg::CFG_MAX_TXN:    max_txn_q = cfg_data_i[10:0];
          fem_pkg::CFG_MIN_MULT:   min_mult_q = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        case (in_i.command)
          fem_pkg::CMD_ADD: begin
            n_add++;
            if (stored_levels.size() >= STORE_DEPTH) n_full++;
          end
          fem_pkg::CMD_CLOSE: n_close++;
          fem_pkg::CMD_QUOTE: n_quote++;
          default: ;
        endcase
        results_due.insert(results_due.size(), fee_predict(in_i));
      end
      if (done_o || cfg_we_i || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer.", IDLE_LIMIT);
        $display("fee_escalation_metrics test failed");
        $finish;
      end
    end
  end

  // Sender: bursts with random gaps; register writes and drains wait for an idle block.
  always @(posedge clk_i) begin
    logic n_start, n_we;
    fem_pkg::in_t n_in;
    logic [fem_pkg::CFG_IDX_W-1:0] n_idx;
    logic [fem_pkg::CFG_W-1:0] n_data;
    n_start = 1'b0;
    n_we = 1'b0;
    n_in = in_i;
    n_idx = cfg_idx_i;
    n_data = cfg_data_i;
    if (rst_ni) begin
      if (!start_i && results_due.size() == 0 && !busy_o) quiet_cycles++;
      else quiet_cycles = 0;
      if (start_i && busy_o) begin
        n_start = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        if (pending_ops[0].kind == OP_ITEM) begin
          n_start = 1'b1;
          n_in = pending_ops.pop_front().item;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else if (quiet_cycles >= 4 && !cfg_we_i) begin
          if (pending_ops[0].kind == OP_CFG) begin
            n_we = 1'b1;
            n_idx = pending_ops[0].idx;
            n_data = pending_ops[0].data;
          end
          void'(pending_ops.pop_front());
        end
      end
    end
    start_i <= n_start;
    in_i <= n_in;
    cfg_we_i <= n_we;
    cfg_idx_i <= n_idx;
    cfg_data_i <= n_data;
  end

  task automatic push_item(logic [1:0] cmd, logic [56:0] fee, logic [31:0] base_drops,
                           logic leap, logic [15:0] open_cnt);
    op_t op;
    op.kind = OP_ITEM;
    op.item = '{command: cmd, fee_drops: fee, base_fee_drops: base_drops,
                time_leap: leap, open_count: open_cnt};
    op.idx = '0;
    op.data = '0;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic push_cfg(logic [fem_pkg::CFG_IDX_W-1:0] idx, logic [fem_pkg::CFG_W-1:0] data);
    op_t op;
    op.kind = OP_CFG;
    op.item = '0;
    op.idx = idx;
    op.data = data;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic push_drain();
    op_t op;
    op.kind = OP_DRAIN;
    op.item = '0;
    op.idx = '0;
    op.data = '0;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  function automatic logic [56:0] rand_fee();
    case ($urandom_range(0, 3))
      0: return 57'($urandom_range(0, 5000));
      1: return 57'({$urandom, $urandom});
      2: return 57'(64'd100000000000000000 - $urandom_range(0, 1000));
      default: return 57'({$urandom, $urandom} >> $urandom_range(0, 56));
    endcase
  endfunction

  function automatic logic [31:0] rand_base_fee();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      default: return 32'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [10:0] rand_count();
    case ($urandom_range(0, 4))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'($urandom);
      default: return 11'($urandom_range(0, 20));
    endcase
  endfunction

  initial begin
    int unsigned n_items;
    int unsigned k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_item(fem_pkg::CMD_QUOTE, '0, '0, 1'b0, 16'd0);
    push_item(fem_pkg::CMD_CLOSE, '0, '0, 1'b0, '0);
    push_item(fem_pkg::CMD_ADD, '0, 32'd10, 1'b0, '0);
    push_item(fem_pkg::CMD_ADD, '1, 32'd1, 1'b0, 16'hFFFF);
    push_item(fem_pkg::CMD_ADD, 57'd100000000000000000, 32'hFFFFFFFF, 1'b1, '0);
    push_item(fem_pkg::CMD_ADD, 57'd12345, 32'd0, 1'b0, '0);
    push_item(CMD_UNUSED, '1, '1, 1'b1, 16'hFFFF);
    push_item(fem_pkg::CMD_CLOSE, '0, '0, 1'b1, '0);
    push_item(fem_pkg::CMD_QUOTE, '0, '0, 1'b0, 16'hFFFF);
    push_item(fem_pkg::CMD_QUOTE, '0, '0, 1'b0, 16'd6);
    push_cfg(fem_pkg::CFG_BASE_LEVEL, 32'd0);
    push_cfg(fem_pkg::CFG_MIN_TXN, 32'd0);
    push_cfg(fem_pkg::CFG_MIN_MULT, 32'hFFFFFFFF);
    push_item(fem_pkg::CMD_ADD, 57'd5000, 32'd7, 1'b0, '0);
    push_item(fem_pkg::CMD_ADD, 57'd0, 32'd0, 1'b0, '0);
    push_item(fem_pkg::CMD_CLOSE, '0, '0, 1'b1, '0);
    push_item(fem_pkg::CMD_CLOSE, '0, '0, 1'b1, '0);
    push_item(fem_pkg::CMD_QUOTE, '0, '0, 1'b0, 16'd1);
    push_cfg(fem_pkg::CFG_BASE_LEVEL, 32'hFFFF);
    push_cfg(fem_pkg::CFG_MIN_MULT, 32'd0);
    push_cfg(fem_pkg::CFG_TARGET_TXN, 32'd1024);
    push_cfg(fem_pkg::CFG_MAX_TXN, 32'd1024);
    push_item(fem_pkg::CMD_QUOTE, '0, '0, 1'b0, 16'hFFFF);

    // Fill the level store to its depth, then overflow it and close the full ledger.
    push_cfg(fem_pkg::CFG_TARGET_TXN, 32'd0);
    push_cfg(fem_pkg::CFG_MAX_TXN, 32'd700);
    for (int i = 0; i < STORE_DEPTH + 2; i++)
      push_item(fem_pkg::CMD_ADD, rand_fee(), 32'($urandom_range(1, 9)), 1'($urandom),
                16'($urandom));
    push_item(fem_pkg::CMD_CLOSE, '0, '0, 1'b0, '0);
    push_item(fem_pkg::CMD_QUOTE, '0, '0, 1'b0, 16'hFFFF);
    push_drain();

    n_items = 0;
    while (n_items < 500) begin
      if ($urandom_range(0, 2) == 0) begin
        push_cfg(fem_pkg::CFG_BASE_LEVEL,
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600));
        push_cfg(fem_pkg::CFG_MIN_TXN, 32'(rand_count()));
        push_cfg(fem_pkg::CFG_TARGET_TXN, 32'(rand_count()));
        push_cfg(fem_pkg::CFG_MAX_TXN, 32'(rand_count()));
        push_cfg(fem_pkg::CFG_MIN_MULT,
                 ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 300000));
      end
      k = $urandom_range(0, 14);
      for (int i = 0; i < k; i++) begin
        push_item(fem_pkg::CMD_ADD, rand_fee(), rand_base_fee(), 1'($urandom),
                  16'($urandom));
        if ($urandom_range(0, 5) == 0) begin
          push_item(fem_pkg::CMD_QUOTE, rand_fee(), $urandom, 1'($urandom),
                    ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30)));
          n_items++;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        push_item(CMD_UNUSED, rand_fee(), $urandom, 1'($urandom), 16'($urandom));
        n_items++;
      end
      push_item(fem_pkg::CMD_CLOSE, rand_fee(), $urandom, 1'($urandom), 16'($urandom));
      push_item(fem_pkg::CMD_QUOTE, rand_fee(), $urandom, 1'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
      n_items += k + 2;
      if ($urandom_range(0, 15) == 0) push_drain();
    end

    while (pending_ops.size() > 0 || start_i || results_due.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (results_due.size() > 0) begin
      mismatches++;
      $display("%0d expected results never arrived.", results_due.size());
    end
    $display("Checked %0d results: %0d adds (%0d into a full store), %0d closes, %0d quotes.",
             n_results, n_add, n_full, n_close, n_quote);
    $display("Field mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("fee_escalation_metrics test passed");
    end else begin
      $display("fee_escalation_metrics test failed");
    end
    $finish;
  end

endmodule
